[hdl/fmc_pkg.sv]
// Shared types and constants of the four-motor command controller.
// Used by fmc_alu, fmc_out_reg and the top level; it depends on nothing.
package fmc_pkg;

  localparam logic       ITEM_COMMAND = 1'b0;
  localparam logic       ITEM_TICK    = 1'b1;

  localparam logic [7:0] CODE_TOGGLE_FIRST = 8'h31;
  localparam logic [7:0] CODE_TOGGLE_LAST  = 8'h34;
  localparam logic [7:0] CODE_RAISE        = 8'h5D;
  localparam logic [7:0] CODE_LOWER        = 8'h5B;

  localparam logic [7:0] DUTY_MAX         = 8'd255;
  localparam logic [7:0] START_DUTY_RESET = 8'd125;
  localparam logic [7:0] RAMP_STEP_RESET  = 8'd5;

  localparam logic       REG_START_DUTY = 1'b0;
  localparam logic       REG_RAMP_STEP  = 1'b1;

  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_FWD  = 2'd1,
    MODE_REV  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ALU_PASS    = 2'd0,
    ALU_INC     = 2'd1,
    ALU_SAT_ADD = 2'd2,
    ALU_SAT_SUB = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic [1:0]  motor_id;
    mode_t       mode;
    logic [7:0]  duty;
    logic        enable;
    logic        brake;
    logic        direction;
    logic [31:0] rev_count;
    logic        last;
  } result_t;

endpackage

[hdl/fmc_alu.sv]
// Shared arithmetic unit: counter increment and saturating duty add and subtract.
// Depends on fmc_pkg for the operation codes.
module fmc_alu #(
  parameter int W = 32
) (
  input  fmc_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     y
);
  import fmc_pkg::*;

  logic [8:0] sum9;

  assign sum9 = {1'b0, a[7:0]} + {1'b0, b[7:0]};

  always_comb begin
    y = a;
    case (op)
      ALU_INC: begin
        y = a + W'(1);
      end
      ALU_SAT_ADD: begin
        y = '0;
        y[7:0] = sum9[8] ? DUTY_MAX : sum9[7:0];
      end
      ALU_SAT_SUB: begin
        y = '0;
        y[7:0] = (a[7:0] > b[7:0]) ? (a[7:0] - b[7:0]) : 8'd0;
      end
      default: begin
        y = a;
      end
    endcase
  end

endmodule

[hdl/fmc_out_reg.sv]
// Output register of the result channel with its valid/stall handshake.
// Depends on fmc_pkg for the result type.
module fmc_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  fmc_pkg::result_t d,
  input  logic             out_stall,
  output logic             out_valid,
  output fmc_pkg::result_t q,
  output logic             free
);
  import fmc_pkg::*;

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

endmodule

[hdl/four_motor_command_controller.sv]
// Four-motor command controller: top level with the motor state and the sequencer.
// Depends on fmc_pkg, fmc_alu and fmc_out_reg.
//
// Requests enter on the input channel (in_valid, in_stall) as a command byte or a
// revolution capture tick. Results leave on the output channel (out_valid, out_stall),
// one result per motor reported, with last set on the final result of a request.
// The registers start_duty and ramp_step are written through cfg_we, cfg_index and
// cfg_data; writing start_duty also loads it into the duty of every motor.
// A request is taken only while the sequencer is idle. A toggle or a capture tick
// passes through the calculate and emit states to the output register, and the
// input opens again once the sequencer is back in idle. A raise or lower command
// visits the motors in turn, each through the calculate state (the shared arithmetic
// unit) and the emit state (loading the output register). Bytes that name no command
// and motors that do not exist give no result.
// The output register lets the next request be accepted while the last result
// still waits. When the receiver stalls, the result holds and the sequencer waits.
// Synchronous reset stops every motor, clears the counts, loads the reset duty and
// drops out_valid.
module four_motor_command_controller #(
  parameter int NUM_MOTORS  = 4,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  code,
  input  logic [1:0]  motor_sel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  motor_id,
  output logic [1:0]  mode,
  output logic [7:0]  duty_out,
  output logic        enable_line,
  output logic        brake_line,
  output logic        direction_line,
  output logic [31:0] rev_count,
  output logic        last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import fmc_pkg::*;

  localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_MOTORS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  typedef enum logic [1:0] {
    JOB_TOGGLE = 2'd0,
    JOB_TICK   = 2'd1,
    JOB_RAISE  = 2'd2,
    JOB_LOWER  = 2'd3
  } job_t;

  state_t                  state, state_next;
  job_t                    job, job_next;
  logic [IDX_W-1:0]        idx, idx_next;
  logic [7:0]              ramp_step;
  mode_t                   motor_mode   [NUM_MOTORS];
  logic [7:0]              motor_duty   [NUM_MOTORS];
  logic [COUNT_WIDTH-1:0]  motor_rounds [NUM_MOTORS];

  logic                    accept;
  logic                    take_job;
  logic [7:0]              toggle_motor;
  mode_t                   sel_mode;
  logic [7:0]              sel_duty;
  logic [COUNT_WIDTH-1:0]  sel_rounds;
  logic [COUNT_WIDTH+31:0] rounds_ext;
  logic                    sel_run;
  logic                    is_ramp;
  logic                    final_result;
  alu_op_t                 alu_op;
  logic [COUNT_WIDTH-1:0]  alu_a;
  logic [COUNT_WIDTH-1:0]  alu_b;
  logic [COUNT_WIDTH-1:0]  alu_y;
  logic                    out_load;
  logic                    out_free;
  result_t                 res_d;
  result_t                 res_q;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  assign toggle_motor = code - CODE_TOGGLE_FIRST;

  assign sel_mode   = motor_mode[idx];
  assign sel_duty   = motor_duty[idx];
  assign sel_rounds = motor_rounds[idx];
  assign rounds_ext = {32'd0, sel_rounds};
  assign sel_run    = (sel_mode == MODE_FWD) || (sel_mode == MODE_REV);

  assign is_ramp      = (job == JOB_RAISE) || (job == JOB_LOWER);
  assign final_result = !is_ramp || (idx == LAST_IDX);

  // Request decode and sequencing.
  always_comb begin
    state_next = state;
    job_next   = job;
    idx_next   = idx;
    take_job   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd == ITEM_TICK) begin
            job_next = JOB_TICK;
            idx_next = IDX_W'(motor_sel);
            take_job = (int'(motor_sel) < NUM_MOTORS);
          end else if (code >= CODE_TOGGLE_FIRST && code <= CODE_TOGGLE_LAST) begin
            job_next = JOB_TOGGLE;
            idx_next = IDX_W'(toggle_motor);
            take_job = (int'(toggle_motor) < NUM_MOTORS);
          end else if (code == CODE_RAISE) begin
            job_next = JOB_RAISE;
            idx_next = '0;
            take_job = 1'b1;
          end else if (code == CODE_LOWER) begin
            job_next = JOB_LOWER;
            idx_next = '0;
            take_job = 1'b1;
          end
          if (take_job) begin
            state_next = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (final_result) begin
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx + IDX_W'(1);
            state_next = ST_CALC;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      job   <= JOB_TOGGLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      job   <= job_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    alu_op = ALU_PASS;
    case (job)
      JOB_TICK:  alu_op = ALU_INC;
      JOB_RAISE: alu_op = ALU_SAT_ADD;
      JOB_LOWER: alu_op = ALU_SAT_SUB;
      default:   alu_op = ALU_PASS;
    endcase
  end

  assign alu_a = (job == JOB_TICK) ? sel_rounds : COUNT_WIDTH'(sel_duty);
  assign alu_b = COUNT_WIDTH'(ramp_step);

  fmc_alu #(
    .W(COUNT_WIDTH)
  ) u_fmc_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_step <= RAMP_STEP_RESET;
    end else if (cfg_we && cfg_index == REG_RAMP_STEP) begin
      ramp_step <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      if (rst) begin
        motor_mode[i]   <= MODE_STOP;
        motor_duty[i]   <= START_DUTY_RESET;
        motor_rounds[i] <= '0;
      end else if (cfg_we && cfg_index == REG_START_DUTY) begin
        motor_duty[i] <= cfg_data;
      end else if (state == ST_CALC && idx == IDX_W'(i)) begin
        case (job)
          JOB_TICK: begin
            motor_rounds[i] <= alu_y;
          end
          JOB_TOGGLE: begin
            case (motor_mode[i])
              MODE_STOP: begin
                motor_mode[i]   <= MODE_FWD;
                motor_rounds[i] <= '0;
              end
              MODE_FWD: begin
                motor_mode[i]   <= MODE_REV;
                motor_rounds[i] <= '0;
              end
              MODE_REV: begin
                motor_mode[i] <= MODE_STOP;
              end
              default: begin
                motor_mode[i] <= motor_mode[i];
              end
            endcase
          end
          default: begin
            if (motor_mode[i] != MODE_STOP) begin
              motor_duty[i] <= alu_y[7:0];
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    res_d.motor_id  = 2'(idx);
    res_d.mode      = sel_mode;
    res_d.duty      = sel_run ? sel_duty : 8'd0;
    res_d.enable    = sel_run;
    res_d.brake     = sel_run;
    res_d.direction = (sel_mode == MODE_FWD);
    res_d.rev_count = rounds_ext[31:0];
    res_d.last      = final_result;
  end

  fmc_out_reg u_fmc_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .d         (res_d),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .q         (res_q),
    .free      (out_free)
  );

  assign motor_id       = res_q.motor_id;
  assign mode           = res_q.mode;
  assign duty_out       = res_q.duty;
  assign enable_line    = res_q.enable;
  assign brake_line     = res_q.brake;
  assign direction_line = res_q.direction;
  assign rev_count      = res_q.rev_count;
  assign last           = res_q.last;

endmodule

[hdl/fmc_checker.sv]
// Port-level checks of the four-motor command controller and their binding.
// Depends only on the ports of four_motor_command_controller.
module fmc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  motor_id,
  input logic [7:0]  duty_out,
  input logic [31:0] rev_count,
  input logic        last
);

  // A held result keeps its motor id, duty, count and last flag.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(motor_id) && $stable(duty_out)
      && $stable(rev_count) && $stable(last))
    else $error("Stalled result changed.");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result shown after reset.");

  // A request whose results are not all out keeps the input side closed.
  assert property (@(posedge clk) disable iff (rst) out_valid && !last |-> in_stall)
    else $error("New request taken during a multi-result sequence.");

endmodule

bind four_motor_command_controller fmc_checker u_fmc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .motor_id  (motor_id),
  .duty_out  (duty_out),
  .rev_count (rev_count),
  .last      (last)
);
